// ===== rtl/core/bounded_deque_list_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque list
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_LIST_TOP_MACROS_SVH
`define BOUNDED_DEQUE_LIST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bdl_pkg.sv =====
// ----------------------------------------------------------------------------
// bdl_pkg
// Command and status codes, record layout and the decode bundle shared by
// the control block and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdl_pkg;

	localparam int unsigned CMD_W  = 3;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned FLD_W  = 8;
	localparam int unsigned REC_W  = 3 * FLD_W;

	localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [STAT_W-1:0] status;
	} bdl_op_t;

endpackage

// ===== rtl/core/bdl_ram.sv =====
// ----------------------------------------------------------------------------
// bdl_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdl_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/core/bdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdl_ctrl
// Head pointer and count of the circular buffer. Decodes one command per
// accepted word into at most one memory access, a status and the new count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdl_ctrl import bdl_pkg::*; #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [CMD_W-1:0]              command,
	input  logic [FLD_W-1:0]              read_index,
	output bdl_op_t                       op,
	output logic [$clog2(CAPACITY)-1:0]   addr,
	output logic [$clog2(CAPACITY+1)-1:0] cnt_next
);

	localparam int unsigned PTR_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned SUM_W = PTR_W + 1;
	localparam int unsigned CMP_W = (CNT_W > FLD_W) ? CNT_W : FLD_W;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);
	localparam logic [SUM_W-1:0] CAP_SUM   = SUM_W'(CAPACITY);

	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_next;
	logic [PTR_W-1:0] head_dec;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_slot;
	logic [PTR_W-1:0] read_slot;
	logic [SUM_W-1:0] tail_sum;
	logic [SUM_W-1:0] read_sum;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             full;
	logic             empty;

	// Both sums stay below twice the capacity, so one subtract wraps them.
	function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= CAP_SUM) ? (s - CAP_SUM) : s;
		return r[PTR_W-1:0];
	endfunction

	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign head_dec  = (head_q == '0) ? LAST_SLOT : (head_q - PTR_W'(1));
	assign head_inc  = (head_q == LAST_SLOT) ? '0 : (head_q + PTR_W'(1));
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_slot = wrap(tail_sum);
	assign idx_ext   = CMP_W'(read_index);
	assign cnt_ext   = CMP_W'(count_q);
	assign read_sum  = SUM_W'(head_q) + SUM_W'(idx_ext);
	assign read_slot = wrap(read_sum);

	always_comb begin
		op        = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_OK};
		addr      = head_q;
		head_next = head_q;
		cnt_next  = count_q;
		unique case (command)
			CMD_PUSH_HEAD: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.wr_en  = 1'b1;
					addr      = head_dec;
					head_next = head_dec;
					cnt_next  = count_q + CNT_W'(1);
				end
			end
			CMD_PUSH_TAIL: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.wr_en = 1'b1;
					addr     = tail_slot;
					cnt_next = count_q + CNT_W'(1);
				end
			end
			CMD_POP_HEAD: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					head_next = head_inc;
					cnt_next  = count_q - CNT_W'(1);
				end
			end
			CMD_POP_TAIL: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					cnt_next = count_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else if (idx_ext >= cnt_ext) begin
					op.status = ST_RANGE;
				end else begin
					op.rd_en = 1'b1;
					addr     = read_slot;
				end
			end
			default: begin
				// unused codes leave the list alone
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_next;
			count_q <= cnt_next;
		end
	end

endmodule

// ===== rtl/core/bounded_deque_list_top.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_list_top
// Bounded double-ended queue of (x, y, symbol) records in a circular buffer.
// done is high for the cycle that follows the accepting edge.
// Throughput: one command per cycle; busy stays low, since each command makes
// at most one access to the single-port record RAM.
// Reset: arst_n clears head pointer and count at once; record RAM is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_deque_list_top_macros.svh"

module bounded_deque_list_top import bdl_pkg::*; #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [CMD_W-1:0]              command,
	input  logic [FLD_W-1:0]              pos_x,
	input  logic [FLD_W-1:0]              pos_y,
	input  logic [FLD_W-1:0]              pos_symbol,
	input  logic [FLD_W-1:0]              read_index,
	output logic                          done,
	output logic [STAT_W-1:0]             status,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic [FLD_W-1:0]              read_x,
	output logic [FLD_W-1:0]              read_y,
	output logic [FLD_W-1:0]              read_symbol
);

	localparam int unsigned PTR_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic             accept;
	bdl_op_t          op;
	logic [PTR_W-1:0] addr;
	logic [CNT_W-1:0] cnt_next;
	logic [REC_W-1:0] wdata;
	logic [REC_W-1:0] rdata;

	logic              valid_s1;
	logic              rd_s1;
	logic [STAT_W-1:0] status_s1;
	logic [CNT_W-1:0]  count_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign wdata  = {pos_symbol, pos_y, pos_x};

	bdl_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.read_index (read_index),
		.op         (op),
		.addr       (addr),
		.cnt_next   (cnt_next)
	);

	bdl_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (accept && op.wr_en),
		.re    (accept && op.rd_en),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_s1    <= 1'b0;
		end else begin
			valid_s1 <= accept;
			rd_s1    <= accept && op.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= op.status;
			count_s1  <= cnt_next;
		end
	end

	// zero the record fields unless a read hit
	assign done        = valid_s1;
	assign status      = status_s1;
	assign entry_count = count_s1;
	assign read_x      = rd_s1 ? rdata[FLD_W-1:0]         : '0;
	assign read_y      = rd_s1 ? rdata[2*FLD_W-1:FLD_W]   : '0;
	assign read_symbol = rd_s1 ? rdata[3*FLD_W-1:2*FLD_W] : '0;

	`BDL_ASSERT_NEXT(a_done_after_accept, start && !busy, done, "done missing after accept")
	`BDL_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done, "done without accept")
	`BDL_ASSERT_NOW(a_count_bound, done, entry_count <= CNT_W'(CAPACITY), "count exceeds capacity")
	`BDL_ASSERT_NOW(a_zero_on_error, done && (status != ST_OK), (read_x == '0) && (read_y == '0) && (read_symbol == '0), "record fields set on error")
	`BDL_ASSERT_NOW(a_full_count, done && (status == ST_FULL), entry_count == CNT_W'(CAPACITY), "full reported below capacity")

endmodule
